### src/assert_macros.svh
// Assertion macros shared by the plotter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GTP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define GTP_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define GTP_ASSERT(label, clk, rst_n, prop)
`define GTP_NEVER(label, clk, rst_n, cond)
`endif
`endif

### src/gtp_pkg.sv
// Types, glyph font and character mapping for the glyph pixel plotter.
`default_nettype none
package gtp_pkg;

	localparam int unsigned NUM_GLYPHS = 43;
	localparam int unsigned GLYPH_W = $clog2(NUM_GLYPHS);

	localparam logic [GLYPH_W-1:0] GLYPH_DOT   = GLYPH_W'(10);
	localparam logic [GLYPH_W-1:0] GLYPH_COLON = GLYPH_W'(11);
	localparam logic [GLYPH_W-1:0] GLYPH_ALPHA = GLYPH_W'(12);
	localparam logic [GLYPH_W-1:0] GLYPH_SPACE = GLYPH_W'(38);
	localparam logic [GLYPH_W-1:0] GLYPH_DASH  = GLYPH_W'(39);
	localparam logic [GLYPH_W-1:0] GLYPH_SLASH = GLYPH_W'(40);
	localparam logic [GLYPH_W-1:0] GLYPH_CHECK = GLYPH_W'(41);
	localparam logic [GLYPH_W-1:0] GLYPH_QUERY = GLYPH_W'(42);

	localparam logic [7:0] CHAR_CHECK_LEAD = 8'hE2;
	localparam logic [7:0] CHAR_CHECK_ALT  = 8'h80;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	localparam logic [8:0] WIDTH_RESET  = 9'd320;
	localparam logic [8:0] HEIGHT_RESET = 9'd240;

	// row 0 in bits 63:56, leftmost column in the MSB of each row
	localparam logic [63:0] GTP_FONT [NUM_GLYPHS] = '{
		64'h3c666e7e76663c00, 64'h1838181818187e00,
		64'h3c66060c18307e00, 64'h3c66061c06663c00, 64'h060e16267e060600,
		64'h7e607c0606663c00, 64'h1c30607c66663c00, 64'h7e060c1830303000,
		64'h3c66663c66663c00, 64'h3c66663e060c3800, 64'h00000000000c0c00,
		64'h00000c0c000c0c00, 64'h3c66667e66666600, 64'h7c66667c66667c00,
		64'h3c66606060663c00, 64'h786c6666666c7800, 64'h7e60607c60607e00,
		64'h7e60607c60606000, 64'h3c66606e66663c00, 64'h6666667e66666600,
		64'h3c18181818183c00, 64'h1e06060606663c00, 64'h666c7870786c6600,
		64'h6060606060607e00, 64'h63777f6b63636300, 64'h66767e7e6e666600,
		64'h3c66666666663c00, 64'h7c66667c60606000, 64'h3c666666663c0e00,
		64'h7c66667c786c6600, 64'h3c66301c06663c00, 64'h7e18181818181800,
		64'h6666666666663c00, 64'h66666666663c1800, 64'h6363636b7f776300,
		64'h66663c183c666600, 64'h6666663c18181800, 64'h7e060c1830607e00,
		64'h0000000000000000, 64'h0000007e00000000, 64'h0002040810204000,
		64'h0001024428100000, 64'h003c425a5a423c00
	};

	typedef struct packed {
		logic [63:0] mask;
		logic [8:0]  x;
		logic [8:0]  y;
		logic [15:0] color;
	} gtp_entry_t;

	function automatic logic [GLYPH_W-1:0] gtp_glyph_index(input logic [7:0] c);
		logic [GLYPH_W-1:0] idx;
		if (c >= "0" && c <= "9") begin
			idx = GLYPH_W'(c - "0");
		end else if (c == ".") begin
			idx = GLYPH_DOT;
		end else if (c == ":") begin
			idx = GLYPH_COLON;
		end else if (c >= "A" && c <= "Z") begin
			idx = GLYPH_W'(c - "A") + GLYPH_ALPHA;
		end else if (c >= "a" && c <= "z") begin
			idx = GLYPH_W'(c - "a") + GLYPH_ALPHA;
		end else if (c == " ") begin
			idx = GLYPH_SPACE;
		end else if (c == "-") begin
			idx = GLYPH_DASH;
		end else if (c == "/") begin
			idx = GLYPH_SLASH;
		end else if (c == CHAR_CHECK_LEAD || c == CHAR_CHECK_ALT) begin
			idx = GLYPH_CHECK;
		end else begin
			idx = GLYPH_QUERY;
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### src/gtp_if.sv
// Request channels of the plotter: character in, pixel write out.
`default_nettype none
interface gtp_char_if;
	logic               valid;
	logic               ready;
	logic [7:0]         char_code;
	logic               new_text;
	logic signed [10:0] start_x;
	logic signed [10:0] start_y;
	logic [15:0]        pixel_color;
	modport source (output valid, char_code, new_text, start_x, start_y, pixel_color,
		input ready);
	modport sink (input valid, char_code, new_text, start_x, start_y, pixel_color,
		output ready);
endinterface

interface gtp_pix_if;
	logic        valid;
	logic        ready;
	logic [16:0] pixel_address;
	logic [15:0] write_color;
	logic        last;
	modport source (output valid, pixel_address, write_color, last, input ready);
	modport sink (input valid, pixel_address, write_color, last, output ready);
endinterface
`default_nettype wire

### src/gtp_front.sv
// Front end: accept characters, track the cursor, build the visible pixel mask.
`default_nettype none
module gtp_front
	import gtp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	gtp_char_if.sink        char_in,
	input  wire logic [8:0] w_eff,
	input  wire logic [8:0] h_eff,
	input  wire logic       q_full,
	output logic            push,
	output gtp_entry_t      push_data
);

	logic signed [10:0] cx_q, cy_q;
	logic signed [10:0] nx, ny;
	logic signed [11:0] adv_sum;
	logic [7:0]         row_vis, col_vis;
	logic [63:0]        glyph;

	assign char_in.ready = !q_full;
	assign push          = char_in.valid && !q_full;

	always_comb begin
		adv_sum = 12'(cx_q) + 12'sd8;
		if (char_in.new_text) begin
			nx = char_in.start_x;
			ny = char_in.start_y;
		end else begin
			nx = (adv_sum > 12'sd1023) ? 11'sd1023 : adv_sum[10:0];
			ny = cy_q;
		end
	end

	always_comb begin
		logic signed [12:0] py, px;
		for (int i = 0; i < 8; i++) begin
			py = 13'(ny) + 13'(i);
			px = 13'(nx) + 13'(i);
			row_vis[i] = (py >= 13'sd0) && (py < $signed({4'b0, h_eff}));
			col_vis[i] = (px >= 13'sd0) && (px < $signed({4'b0, w_eff}));
		end
	end

	assign glyph = GTP_FONT[gtp_glyph_index(char_in.char_code)];

	always_comb begin
		for (int k = 0; k < 64; k++) begin
			push_data.mask[k] = glyph[63-k] && row_vis[k/8] && col_vis[k%8];
		end
		push_data.x     = nx[8:0];
		push_data.y     = ny[8:0];
		push_data.color = char_in.pixel_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (push) begin
			cx_q <= nx;
			cy_q <= ny;
		end
	end

endmodule
`default_nettype wire

### src/gtp_queue.sv
// Two-entry queue between the front end and the pixel scanner.
`default_nettype none
`include "assert_macros.svh"
module gtp_queue
	import gtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire gtp_entry_t  push_data,
	output logic             full,
	input  wire logic        pop,
	output logic             nonempty,
	output gtp_entry_t       pop_data
);

	gtp_entry_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	`GTP_NEVER(a_no_overflow, clk, arst_n, push && full)
	`GTP_NEVER(a_no_underflow, clk, arst_n, pop && !nonempty)

endmodule
`default_nettype wire

### src/gtp_back.sv
// Back end: scan the pixel mask and issue one framebuffer write per cycle while pix_out is not stalled.
`default_nettype none
`include "assert_macros.svh"
module gtp_back
	import gtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [8:0]  w_eff,
	input  wire logic        q_nonempty,
	input  wire gtp_entry_t  q_data,
	output logic             pop,
	gtp_pix_if.source        pix_out
);

	logic [63:0] mask_q;
	logic [8:0]  x_q, y_q;
	logic [15:0] color_q;

	logic        s1_v;
	logic [8:0]  py_s1, px_s1;
	logic [15:0] color_s1;
	logic        last_s1;

	logic        out_v_q;
	logic [16:0] addr_q;
	logic [15:0] out_color_q;
	logic        out_last_q;

	logic        adv, pick;
	logic [63:0] rest;
	logic [5:0]  k;

	assign adv  = !out_v_q || pix_out.ready;
	assign pick = (mask_q != '0) && adv;
	assign rest = mask_q & (mask_q - 64'd1);
	assign pop  = q_nonempty && ((mask_q == '0) || (adv && rest == '0));

	always_comb begin
		k = '0;
		for (int b = 63; b >= 0; b--) begin
			if (mask_q[b]) k = 6'(b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			s1_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= q_data.mask;
			end else if (pick) begin
				mask_q <= rest;
			end
			if (adv) begin
				s1_v    <= pick;
				out_v_q <= s1_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q     <= q_data.x;
			y_q     <= q_data.y;
			color_q <= q_data.color;
		end
		if (adv) begin
			py_s1       <= y_q + 9'(k[5:3]);
			px_s1       <= x_q + 9'(k[2:0]);
			color_s1    <= color_q;
			last_s1     <= (rest == '0);
			addr_q      <= 17'(18'(py_s1) * 18'(w_eff) + 18'(px_s1));
			out_color_q <= color_s1;
			out_last_q  <= last_s1;
		end
	end

	assign pix_out.valid         = out_v_q;
	assign pix_out.pixel_address = addr_q;
	assign pix_out.write_color   = out_color_q;
	assign pix_out.last          = out_last_q;

	`GTP_ASSERT(a_more_pixels_follow, clk, arst_n, (s1_v && !last_s1) |-> (mask_q != '0))
	`GTP_NEVER(a_pick_only_when_loaded, clk, arst_n, pick && pop && (rest != '0))

endmodule
`default_nettype wire

### src/glyph_text_pixel_plotter.sv
// Top level of the 8x8 glyph text pixel plotter.
// Usage:
//   char_in carries one text character per request (code, new_text, start
//   position, color); pix_out carries framebuffer writes (address, color,
//   last). Both use valid/ready; a request moves when both are high.
//   wr_en/wr_index/wr_data write display_width (index 0) and
//   display_height (index 1); write only while the block is idle.
//   Each character yields one write per visible set glyph pixel, scanned
//   row by row, left to right; last marks the final write of a character.
//   A character with no visible pixel yields nothing.
//   The first write of a character passes the queue, the mask register, the
//   scan stage and the output register. The pixel scanner issues one write
//   per cycle while pix_out is not stalled; a character gives N writes,
//   N the visible pixel count (at most 64).
//   A two-entry queue lets char_in keep accepting while pixels drain.
//   Reset clears the cursor to (0,0), empties the pipeline and restores
//   width 320 and height 240. When pix_out stalls, the write held on it
//   stays put and the scanner and queue fill, then char_in drops ready.
`default_nettype none
module glyph_text_pixel_plotter
	import gtp_pkg::*;
#(
	parameter int unsigned MAX_DIM = 320
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire logic [0:0] wr_index,
	input  wire logic [8:0] wr_data,
	gtp_char_if.sink        char_in,
	gtp_pix_if.source       pix_out
);

	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1) > 9 ? $clog2(MAX_DIM + 1) : 9;

	logic [8:0] width_q, height_q;
	logic [8:0] w_eff, h_eff;
	logic       push, q_full, pop, q_nonempty;
	gtp_entry_t push_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	assign w_eff = (DIM_W'(width_q) > DIM_W'(MAX_DIM)) ? 9'(MAX_DIM) : width_q;
	assign h_eff = (DIM_W'(height_q) > DIM_W'(MAX_DIM)) ? 9'(MAX_DIM) : height_q;

	gtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	gtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.pop_data  (q_data)
	);

	gtp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.w_eff      (w_eff),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.pop        (pop),
		.pix_out    (pix_out)
	);

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the glyph text pixel plotter: directed and random text runs.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import gtp_pkg::*;

	localparam int VIS_MAX = 320;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 100;

	localparam logic [63:0] FONT_ROWS [43] = '{
		64'h3c666e7e76663c00, 64'h1838181818187e00, 64'h3c66060c18307e00,
		64'h3c66061c06663c00, 64'h060e16267e060600, 64'h7e607c0606663c00,
		64'h1c30607c66663c00, 64'h7e060c1830303000, 64'h3c66663c66663c00,
		64'h3c66663e060c3800, 64'h00000000000c0c00, 64'h00000c0c000c0c00,
		64'h3c66667e66666600, 64'h7c66667c66667c00, 64'h3c66606060663c00,
		64'h786c6666666c7800, 64'h7e60607c60607e00, 64'h7e60607c60606000,
		64'h3c66606e66663c00, 64'h6666667e66666600, 64'h3c18181818183c00,
		64'h1e06060606663c00, 64'h666c7870786c6600, 64'h6060606060607e00,
		64'h63777f6b63636300, 64'h66767e7e6e666600, 64'h3c66666666663c00,
		64'h7c66667c60606000, 64'h3c666666663c0e00, 64'h7c66667c786c6600,
		64'h3c66301c06663c00, 64'h7e18181818181800, 64'h6666666666663c00,
		64'h66666666663c1800, 64'h6363636b7f776300, 64'h66663c183c666600,
		64'h6666663c18181800, 64'h7e060c1830607e00, 64'h0000000000000000,
		64'h0000007e00000000, 64'h0002040810204000, 64'h0001024428100000,
		64'h003c425a5a423c00
	};

	typedef struct packed {
		logic [16:0] addr;
		logic [15:0] color;
		logic        last;
	} pixel_write_t;

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	logic [0:0] wr_index;
	logic [8:0] wr_data;

	gtp_char_if char_ch ();
	gtp_pix_if  pix_ch ();

	glyph_text_pixel_plotter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.char_in  (char_ch),
		.pix_out  (pix_ch)
	);

	pixel_write_t pending_writes [$];
	logic [8:0]   disp_width;
	logic [8:0]   disp_height;
	int           pen_x;
	int           pen_y;
	int           mismatches;
	int           cycle_count;
	int           send_gap_pct;
	int           stall_pct;
	string        glyph_chars = "0123456789.:ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz -/";

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : check_writes
		pixel_write_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (pending_writes.size() == 0) begin
				report_mismatch("unexpected pixel write", 32'(pix_ch.pixel_address), 0);
			end else begin
				want = pending_writes.pop_front();
				if (pix_ch.pixel_address !== want.addr)
					report_mismatch("pixel_address", 32'(pix_ch.pixel_address), 32'(want.addr));
				if (pix_ch.write_color !== want.color)
					report_mismatch("write_color", 32'(pix_ch.write_color), 32'(want.color));
				if (pix_ch.last !== want.last)
					report_mismatch("last", 32'(pix_ch.last), 32'(want.last));
			end
		end
		pix_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic int glyph_for(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c == ".") return int'(GLYPH_DOT);
		if (c == ":") return int'(GLYPH_COLON);
		if (c >= "A" && c <= "Z") return int'(GLYPH_ALPHA) + int'(c - "A");
		if (c >= "a" && c <= "z") return int'(GLYPH_ALPHA) + int'(c - "a");
		if (c == " ") return int'(GLYPH_SPACE);
		if (c == "-") return int'(GLYPH_DASH);
		if (c == "/") return int'(GLYPH_SLASH);
		if (c == CHAR_CHECK_LEAD || c == CHAR_CHECK_ALT) return int'(GLYPH_CHECK);
		return int'(GLYPH_QUERY);
	endfunction

	function automatic int visible_width();
		return (int'(disp_width) > VIS_MAX) ? VIS_MAX : int'(disp_width);
	endfunction

	function automatic int visible_height();
		return (int'(disp_height) > VIS_MAX) ? VIS_MAX : int'(disp_height);
	endfunction

	task automatic plot_glyph(input logic [7:0] code, input logic nt,
		input logic signed [10:0] sx, input logic signed [10:0] sy, input logic [15:0] color);
		int w;
		int h;
		int px;
		int py;
		int count;
		logic [63:0] rows;
		pixel_write_t wr;
		if (nt) begin
			pen_x = sx;
			pen_y = sy;
		end else begin
			pen_x = (pen_x + 8 > 1023) ? 1023 : pen_x + 8;
		end
		w = visible_width();
		h = visible_height();
		rows = FONT_ROWS[glyph_for(code)];
		count = 0;
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++) begin
				px = pen_x + j;
				py = pen_y + i;
				if (rows[63 - 8 * i - j] && px >= 0 && py >= 0 && px < w && py < h) begin
					wr.addr = 17'(py * w + px);
					wr.color = color;
					wr.last = 1'b0;
					pending_writes.push_back(wr);
					count++;
				end
			end
		end
		if (count > 0)
			pending_writes[pending_writes.size() - 1].last = 1'b1;
	endtask

	task automatic send_char(input logic [7:0] code, input logic nt,
		input logic signed [10:0] sx, input logic signed [10:0] sy, input logic [15:0] color);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_code <= code;
		char_ch.new_text <= nt;
		char_ch.start_x <= sx;
		char_ch.start_y <= sy;
		char_ch.pixel_color <= color;
		@(posedge clk);
		while (!char_ch.ready) @(posedge clk);
		plot_glyph(code, nt, sx, sy, color);
	endtask

	task automatic wait_drained();
		char_ch.valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [8:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_WIDTH) disp_width = data;
		else disp_height = data;
		@(posedge clk);
	endtask

	task automatic set_display(input int w, input int h);
		wait_drained();
		write_reg(REG_WIDTH, 9'(w));
		write_reg(REG_HEIGHT, 9'(h));
	endtask

	task automatic test_reset_advance();
		send_char("A", 1'b0, 11'sd5, -11'sd7, 16'hffff);
	endtask

	task automatic test_glyph_set();
		send_char("0", 1'b1, 11'sd16, 11'sd16, 16'h0000);
		send_char("9", 1'b0, 11'sd0, 11'sd0, 16'hffff);
		send_char(".", 1'b0, 11'sd0, 11'sd0, 16'ha5a5);
		send_char(":", 1'b0, 11'sd0, 11'sd0, 16'h5a5a);
		send_char("Z", 1'b0, 11'sd0, 11'sd0, 16'h0001);
		send_char("a", 1'b0, 11'sd0, 11'sd0, 16'h8000);
		send_char(" ", 1'b0, 11'sd0, 11'sd0, 16'hffff);
		send_char("-", 1'b0, 11'sd0, 11'sd0, 16'h1234);
		send_char("/", 1'b0, 11'sd0, 11'sd0, 16'hedcb);
		send_char(CHAR_CHECK_LEAD, 1'b0, 11'sd0, 11'sd0, 16'h0f0f);
		send_char(CHAR_CHECK_ALT, 1'b0, 11'sd0, 11'sd0, 16'hf0f0);
		send_char(8'hff, 1'b0, 11'sd0, 11'sd0, 16'h7fff);
	endtask

	task automatic test_clipping();
		send_char("W", 1'b1, 11'sh400, 11'sh400, 16'hffff);
		send_char("H", 1'b1, -11'sd4, -11'sd3, 16'h00ff);
		send_char("B", 1'b1, 11'sd316, 11'sd236, 16'hff00);
	endtask

	task automatic test_advance_saturation();
		send_char("X", 1'b1, 11'sd1014, 11'sd10, 16'h3333);
		send_char("X", 1'b0, 11'sd1023, 11'sd1023, 16'hcccc);
		send_char("M", 1'b0, 11'sd0, 11'sd0, 16'h4444);
	endtask

	task automatic test_display_size();
		set_display(0, 240);
		send_char("A", 1'b1, 11'sd0, 11'sd0, 16'h1111);
		set_display(320, 0);
		send_char("A", 1'b1, 11'sd0, 11'sd0, 16'h2222);
		set_display(511, 320);
		send_char("O", 1'b1, 11'sd316, 11'sd312, 16'h5555);
		set_display(1, 1);
		send_char("1", 1'b1, -11'sd3, 11'sd0, 16'haaaa);
	endtask

	task automatic test_random_text(input int gap_pct, input int hold_pct, input int n_items);
		int pick;
		int w;
		int h;
		logic [7:0] code;
		logic nt;
		logic signed [10:0] sx;
		logic signed [10:0] sy;
		send_gap_pct = gap_pct;
		stall_pct = hold_pct;
		w = visible_width();
		h = visible_height();
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 12) begin
				code = 8'($urandom_range(0, 255));
				nt = 1'($urandom_range(0, 1));
				sx = 11'($urandom);
				sy = 11'($urandom);
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0) code = CHAR_CHECK_LEAD;
				else if (pick == 1) code = CHAR_CHECK_ALT;
				else if (pick < 4) code = 8'($urandom_range(0, 255));
				else code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
				nt = (k == 0 || $urandom_range(0, 7) == 0);
				if (nt) begin
					sx = 11'(int'($urandom_range(0, w + 8)) - 8);
					sy = 11'(int'($urandom_range(0, h + 8)) - 8);
				end else begin
					sx = 11'($urandom);
					sy = 11'($urandom);
				end
			end
			send_char(code, nt, sx, sy, 16'($urandom));
		end
	endtask

	initial begin
		mismatches = 0;
		send_gap_pct = 0;
		stall_pct = 0;
		pen_x = 0;
		pen_y = 0;
		disp_width = WIDTH_RESET;
		disp_height = HEIGHT_RESET;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_WIDTH;
		wr_data <= '0;
		char_ch.valid <= 1'b0;
		char_ch.char_code <= '0;
		char_ch.new_text <= 1'b0;
		char_ch.start_x <= '0;
		char_ch.start_y <= '0;
		char_ch.pixel_color <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_advance();
		test_glyph_set();
		test_clipping();
		test_advance_saturation();
		test_display_size();

		set_display(320, 240);
		test_random_text(0, 0, 22);
		set_display(int'($urandom_range(1, 511)), int'($urandom_range(1, 511)));
		test_random_text(46, 0, 22);
		set_display(511, 511);
		test_random_text(0, 46, 22);
		set_display(int'($urandom_range(1, 320)), int'($urandom_range(1, 320)));
		test_random_text(21, 21, 22);

		wait_drained();
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

### files.f
+incdir+src
src/gtp_pkg.sv
src/gtp_if.sv
src/gtp_front.sv
src/gtp_queue.sv
src/gtp_back.sv
src/glyph_text_pixel_plotter.sv
dv/testbench.sv
